### rtl/sftc_pkg.sv
package sftc_pkg;

   localparam int FRAME_WIDTH   = 52;
   localparam int SECONDS_WIDTH = 32;
   localparam int NSEC_WIDTH    = 31;
   localparam int RATE_WIDTH    = 20;
   localparam int RATE_RESET    = 48000;
   localparam int NS_PER_SEC    = 1000000000;
   localparam int NS_MAX        = 999999999;
   localparam int DIV_WIDTH     = 30;
   localparam int QUO_WIDTH     = 64;
   localparam int DIV_STEPS     = 4;
   localparam int DIV1_STAGES   = (FRAME_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV1_BITS     = DIV1_STAGES * DIV_STEPS;
   localparam int DIV2_BITS     = 32;
   localparam int DIV2_STAGES   = DIV2_BITS / DIV_STEPS;
   localparam int PROD_WIDTH    = 50;
   localparam int WHOLE_WIDTH   = 33;
   localparam int ADDR_WIDTH    = 2;
   localparam int DATA_WIDTH    = 32;

   localparam logic [ADDR_WIDTH-1:0] REG_RATE_ADDR = 2'd0;

   typedef enum logic [1:0] {
      ACT_TO_TIME   = 2'd0,
      ACT_TO_FRAME  = 2'd1,
      ACT_NORMALIZE = 2'd2,
      ACT_NONE      = 2'd3
   } action_type;

   typedef struct packed {
      action_type             action;
      logic                   neg;
      logic [QUO_WIDTH-1:0]   mag;
      logic [DIV_WIDTH-1:0]   frac;
   } side_type;

endpackage

### rtl/sftc_front.sv
module sftc_front (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     valid_i,
   input  logic [1:0]                               action_i,
   input  logic signed [sftc_pkg::FRAME_WIDTH-1:0]  frame_i,
   input  logic signed [31:0]                       seconds_i,
   input  logic signed [31:0]                       nanoseconds_i,
   output logic                                     valid_o,
   output sftc_pkg::side_type                       side_o
);

   localparam logic signed [34:0] BIL = 35'(sftc_pkg::NS_PER_SEC);

   logic                valid_ff;
   sftc_pkg::side_type  side_ff;
   sftc_pkg::side_type  side_in;

   logic signed [34:0]  sec_x;
   logic signed [34:0]  ns_x;
   logic signed [34:0]  r_x;
   logic signed [34:0]  s_x;
   logic signed [34:0]  whole_x;
   logic [sftc_pkg::DIV_WIDTH-1:0]   frac_x;
   logic [sftc_pkg::FRAME_WIDTH-1:0] m_x;
   logic                f_neg;
   logic                t_neg;

   always_comb begin
      sec_x = 35'(seconds_i);
      ns_x  = 35'(nanoseconds_i);
      // split nanoseconds into whole seconds and a remainder in [0, 1e9)
      priority if (ns_x < -(BIL + BIL)) begin
         r_x = ns_x + BIL + BIL + BIL;
         s_x = sec_x - 35'sd3;
      end else if (ns_x < -BIL) begin
         r_x = ns_x + BIL + BIL;
         s_x = sec_x - 35'sd2;
      end else if (ns_x < 35'sd0) begin
         r_x = ns_x + BIL;
         s_x = sec_x - 35'sd1;
      end else if (ns_x < BIL) begin
         r_x = ns_x;
         s_x = sec_x;
      end else if (ns_x < BIL + BIL) begin
         r_x = ns_x - BIL;
         s_x = sec_x + 35'sd1;
      end else begin
         r_x = ns_x - BIL - BIL;
         s_x = sec_x + 35'sd2;
      end
      t_neg = s_x[34];
      if (t_neg) begin
         if (r_x == 35'sd0) begin
            whole_x = -s_x;
            frac_x  = '0;
         end else begin
            whole_x = -s_x - 35'sd1;
            frac_x  = sftc_pkg::DIV_WIDTH'(BIL - r_x);
         end
      end else begin
         whole_x = s_x;
         frac_x  = sftc_pkg::DIV_WIDTH'(r_x);
      end

      f_neg = frame_i[sftc_pkg::FRAME_WIDTH-1];
      m_x   = f_neg ? (~frame_i + 1'b1) : frame_i;

      side_in.action = sftc_pkg::action_type'(action_i);
      side_in.frac   = frac_x;
      if (side_in.action == sftc_pkg::ACT_TO_TIME) begin
         side_in.neg = f_neg;
         side_in.mag = sftc_pkg::QUO_WIDTH'(m_x);
      end else begin
         side_in.neg = t_neg;
         side_in.mag = sftc_pkg::QUO_WIDTH'(whole_x[sftc_pkg::WHOLE_WIDTH-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      side_ff <= side_in;
   end

   assign valid_o = valid_ff;
   assign side_o  = side_ff;

endmodule

### rtl/sftc_div_stage.sv
module sftc_div_stage (
   input  logic                             clock,
   input  logic [sftc_pkg::DIV_WIDTH-1:0]   rem_i,
   input  logic [sftc_pkg::QUO_WIDTH-1:0]   quo_i,
   input  logic [sftc_pkg::DIV_WIDTH-1:0]   dvs_i,
   output logic [sftc_pkg::DIV_WIDTH-1:0]   rem_o,
   output logic [sftc_pkg::QUO_WIDTH-1:0]   quo_o,
   output logic [sftc_pkg::DIV_WIDTH-1:0]   dvs_o
);

   logic [sftc_pkg::DIV_WIDTH-1:0] rem_ff;
   logic [sftc_pkg::QUO_WIDTH-1:0] quo_ff;
   logic [sftc_pkg::DIV_WIDTH-1:0] dvs_ff;
   logic [sftc_pkg::DIV_WIDTH-1:0] rem_in;
   logic [sftc_pkg::QUO_WIDTH-1:0] quo_in;
   logic [sftc_pkg::DIV_WIDTH:0]   trial;

   // restoring division, dividend bits enter from the top of quo
   always_comb begin
      rem_in = rem_i;
      quo_in = quo_i;
      trial  = '0;
      for (int s = 0; s < sftc_pkg::DIV_STEPS; s++) begin
         trial  = {rem_in, quo_in[sftc_pkg::QUO_WIDTH-1]};
         quo_in = {quo_in[sftc_pkg::QUO_WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, dvs_i}) begin
            rem_in    = sftc_pkg::DIV_WIDTH'(trial - {1'b0, dvs_i});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[sftc_pkg::DIV_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_i;
   end

   assign rem_o = rem_ff;
   assign quo_o = quo_ff;
   assign dvs_o = dvs_ff;

endmodule

### rtl/sftc_mul.sv
module sftc_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid_i,
   input  sftc_pkg::side_type                side_i,
   input  logic [sftc_pkg::DIV_WIDTH-1:0]    rem_i,
   input  logic [sftc_pkg::QUO_WIDTH-1:0]    quo_i,
   input  logic [sftc_pkg::RATE_WIDTH-1:0]   rate_i,
   output logic                              valid_o,
   output sftc_pkg::side_type                side_o,
   output logic [sftc_pkg::DIV_WIDTH-1:0]    rem_o,
   output logic [sftc_pkg::QUO_WIDTH-1:0]    quo_o,
   output logic [sftc_pkg::DIV_WIDTH-1:0]    dvs_o
);

   localparam logic [sftc_pkg::DIV_WIDTH-1:0] BIL = sftc_pkg::DIV_WIDTH'(sftc_pkg::NS_PER_SEC);

   logic                                valid_ff;
   sftc_pkg::side_type                  side_ff;
   logic [sftc_pkg::DIV_WIDTH-1:0]      rem_ff;
   logic [sftc_pkg::QUO_WIDTH-1:0]      quo_ff;
   logic [sftc_pkg::DIV_WIDTH-1:0]      dvs_ff;

   sftc_pkg::side_type                  side_in;
   logic [sftc_pkg::RATE_WIDTH-1:0]     mul_a;
   logic [sftc_pkg::DIV_WIDTH-1:0]      mul_b;
   logic [sftc_pkg::PROD_WIDTH-1:0]     prod;
   logic [sftc_pkg::DIV_WIDTH-1:0]      dvs_in;

   always_comb begin
      side_in = side_i;
      if (side_i.action == sftc_pkg::ACT_TO_TIME) begin
         // fraction of a second: rem * 1e9 / rate
         side_in.mag = quo_i;
         mul_a       = rem_i[sftc_pkg::RATE_WIDTH-1:0];
         mul_b       = BIL;
         dvs_in      = sftc_pkg::DIV_WIDTH'(rate_i);
      end else begin
         // frames from fraction: (frac + 1) * rate / 1e9
         mul_a  = rate_i;
         mul_b  = side_i.frac + 1'b1;
         dvs_in = BIL;
      end
      if (side_i.action == sftc_pkg::ACT_TO_FRAME) begin
         side_in.mag = sftc_pkg::QUO_WIDTH'(side_i.mag[sftc_pkg::WHOLE_WIDTH-1:0] * rate_i);
      end
      prod = sftc_pkg::PROD_WIDTH'(mul_a * mul_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      side_ff <= side_in;
      rem_ff  <= sftc_pkg::DIV_WIDTH'(prod[sftc_pkg::PROD_WIDTH-1:sftc_pkg::DIV2_BITS]);
      quo_ff  <= {prod[sftc_pkg::DIV2_BITS-1:0], {(sftc_pkg::QUO_WIDTH-sftc_pkg::DIV2_BITS){1'b0}}};
      dvs_ff  <= dvs_in;
   end

   assign valid_o = valid_ff;
   assign side_o  = side_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;
   assign dvs_o   = dvs_ff;

endmodule

### rtl/sftc_back.sv
module sftc_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     valid_i,
   input  sftc_pkg::side_type                       side_i,
   input  logic [sftc_pkg::QUO_WIDTH-1:0]           quo_i,
   output logic                                     strobe_o,
   output logic signed [31:0]                       seconds_o,
   output logic signed [sftc_pkg::NSEC_WIDTH-1:0]   nanoseconds_o,
   output logic signed [sftc_pkg::FRAME_WIDTH-1:0]  frame_o,
   output logic                                     overflow_o
);

   localparam int FW = sftc_pkg::FRAME_WIDTH;

   logic                                  strobe_ff;
   logic signed [31:0]                    seconds_ff;
   logic signed [sftc_pkg::NSEC_WIDTH-1:0] ns_ff;
   logic signed [FW-1:0]                  frame_ff;
   logic                                  ovf_ff;

   logic [31:0]                           seconds_in;
   logic [sftc_pkg::NSEC_WIDTH-1:0]       ns_in;
   logic [FW-1:0]                         frame_in;
   logic                                  ovf_in;

   logic [sftc_pkg::QUO_WIDTH-1:0]        smag;
   logic [sftc_pkg::DIV_WIDTH-1:0]        nmag;
   logic [sftc_pkg::QUO_WIDTH-1:0]        s_lim;
   logic [31:0]                           s_sat;
   logic [sftc_pkg::NSEC_WIDTH-1:0]       n_sat;
   logic                                  s_ovf;
   logic [sftc_pkg::QUO_WIDTH:0]          fm;
   logic [sftc_pkg::QUO_WIDTH:0]          f_lim;
   logic [FW-1:0]                         f_sat;
   logic                                  f_ovf;

   always_comb begin
      if (side_i.action == sftc_pkg::ACT_TO_TIME) begin
         smag = side_i.mag;
         nmag = quo_i[sftc_pkg::DIV_WIDTH-1:0];
      end else begin
         smag = side_i.mag;
         nmag = side_i.frac;
      end
      s_lim = (sftc_pkg::QUO_WIDTH'(1) << 31) - (side_i.neg ? '0 : sftc_pkg::QUO_WIDTH'(1));
      s_ovf = smag > s_lim;
      s_sat = s_ovf ? s_lim[31:0] : smag[31:0];
      n_sat = s_ovf ? sftc_pkg::NSEC_WIDTH'(sftc_pkg::NS_MAX) : sftc_pkg::NSEC_WIDTH'(nmag);
      if (side_i.neg) begin
         s_sat = ~s_sat + 1'b1;
         n_sat = ~n_sat + 1'b1;
      end

      fm    = {1'b0, side_i.mag} + (sftc_pkg::QUO_WIDTH + 1)'(quo_i[sftc_pkg::DIV2_BITS-1:0]);
      f_lim = ((sftc_pkg::QUO_WIDTH + 1)'(1) << (FW - 1))
              - (side_i.neg ? '0 : (sftc_pkg::QUO_WIDTH + 1)'(1));
      f_ovf = fm > f_lim;
      f_sat = f_ovf ? f_lim[FW-1:0] : fm[FW-1:0];
      if (side_i.neg) begin
         f_sat = ~f_sat + 1'b1;
      end

      unique case (side_i.action)
         sftc_pkg::ACT_TO_TIME, sftc_pkg::ACT_NORMALIZE: begin
            seconds_in = s_sat;
            ns_in      = n_sat;
            frame_in   = '0;
            ovf_in     = s_ovf;
         end
         sftc_pkg::ACT_TO_FRAME: begin
            seconds_in = '0;
            ns_in      = '0;
            frame_in   = f_sat;
            ovf_in     = f_ovf;
         end
         default: begin
            seconds_in = '0;
            ns_in      = '0;
            frame_in   = '0;
            ovf_in     = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid_i;
      end
      seconds_ff <= seconds_in;
      ns_ff      <= ns_in;
      frame_ff   <= frame_in;
      ovf_ff     <= ovf_in;
   end

   assign strobe_o      = strobe_ff;
   assign seconds_o     = seconds_ff;
   assign nanoseconds_o = ns_ff;
   assign frame_o       = frame_ff;
   assign overflow_o    = ovf_ff;

endmodule

### rtl/sample_frame_time_converter.sv
// Channel   | Handshake               | Payload
// request   | start / busy            | req_action, req_frame_in, req_seconds_in,
//           |                         | req_nanoseconds_in
// result    | rsp_strobe (one cycle)  | rsp_seconds_out, rsp_nanoseconds_out,
//           |                         | rsp_frame_out, rsp_overflow
// csr       | psel/penable/pready     | paddr, pwrite, pwdata, prdata (sample_rate)
//
// One request per cycle; busy stays low. Path: front stage, 4-bit-per-stage
// divider, multiplier, second such divider and back stage, each registered.
// Synchronous reset clears the valid bits and sets sample_rate to 48000.
// The receiver cannot stall: each result shows for one cycle with rsp_strobe.
module sample_frame_time_converter (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic [1:0]                               req_action,
   input  logic signed [sftc_pkg::FRAME_WIDTH-1:0]  req_frame_in,
   input  logic signed [31:0]                       req_seconds_in,
   input  logic signed [31:0]                       req_nanoseconds_in,
   output logic                                     rsp_strobe,
   output logic signed [31:0]                       rsp_seconds_out,
   output logic signed [sftc_pkg::NSEC_WIDTH-1:0]   rsp_nanoseconds_out,
   output logic signed [sftc_pkg::FRAME_WIDTH-1:0]  rsp_frame_out,
   output logic                                     rsp_overflow,
   input  logic                                     psel,
   input  logic                                     penable,
   input  logic                                     pwrite,
   input  logic [sftc_pkg::ADDR_WIDTH-1:0]          paddr,
   input  logic [sftc_pkg::DATA_WIDTH-1:0]          pwdata,
   output logic [sftc_pkg::DATA_WIDTH-1:0]          prdata,
   output logic                                     pready
);

   localparam int D1 = sftc_pkg::DIV1_STAGES;
   localparam int D2 = sftc_pkg::DIV2_STAGES;

   logic [sftc_pkg::RATE_WIDTH-1:0] rate_ff;
   logic [sftc_pkg::RATE_WIDTH-1:0] rate_eff;

   logic                f_valid;
   sftc_pkg::side_type  f_side;

   logic [sftc_pkg::DIV_WIDTH-1:0] d1_rem [D1+1];
   logic [sftc_pkg::QUO_WIDTH-1:0] d1_quo [D1+1];
   logic [sftc_pkg::DIV_WIDTH-1:0] d1_dvs [D1+1];
   logic [D1-1:0]                  d1_valid_ff;
   sftc_pkg::side_type             d1_side_ff [D1];

   logic                           m_valid;
   sftc_pkg::side_type             m_side;
   logic [sftc_pkg::DIV_WIDTH-1:0] d2_rem [D2+1];
   logic [sftc_pkg::QUO_WIDTH-1:0] d2_quo [D2+1];
   logic [sftc_pkg::DIV_WIDTH-1:0] d2_dvs [D2+1];
   logic [D2-1:0]                  d2_valid_ff;
   sftc_pkg::side_type             d2_side_ff [D2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= sftc_pkg::RATE_WIDTH'(sftc_pkg::RATE_RESET);
      end else if (psel && penable && pwrite && paddr == sftc_pkg::REG_RATE_ADDR) begin
         rate_ff <= pwdata[sftc_pkg::RATE_WIDTH-1:0];
      end
   end

   assign pready   = 1'b1;
   assign prdata   = (paddr == sftc_pkg::REG_RATE_ADDR) ?
                     sftc_pkg::DATA_WIDTH'(rate_ff) : '0;
   assign rate_eff = (rate_ff == '0) ? sftc_pkg::RATE_WIDTH'(1) : rate_ff;
   assign busy     = 1'b0;

   sftc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .valid_i       (start),
      .action_i      (req_action),
      .frame_i       (req_frame_in),
      .seconds_i     (req_seconds_in),
      .nanoseconds_i (req_nanoseconds_in),
      .valid_o       (f_valid),
      .side_o        (f_side)
   );

   // frame magnitude / rate, left-aligned dividend
   assign d1_rem[0] = '0;
   assign d1_quo[0] = f_side.mag[sftc_pkg::QUO_WIDTH-1:0]
                      << (sftc_pkg::QUO_WIDTH - sftc_pkg::DIV1_BITS);
   assign d1_dvs[0] = sftc_pkg::DIV_WIDTH'(rate_eff);

   for (genvar g = 0; g < D1; g++) begin : g_div1
      sftc_div_stage u_stage (
         .clock (clock),
         .rem_i (d1_rem[g]),
         .quo_i (d1_quo[g]),
         .dvs_i (d1_dvs[g]),
         .rem_o (d1_rem[g+1]),
         .quo_o (d1_quo[g+1]),
         .dvs_o (d1_dvs[g+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff <= '0;
         d2_valid_ff <= '0;
      end else begin
         d1_valid_ff <= {d1_valid_ff[D1-2:0], f_valid};
         d2_valid_ff <= {d2_valid_ff[D2-2:0], m_valid};
      end
      d1_side_ff[0] <= f_side;
      for (int i = 1; i < D1; i++) begin
         d1_side_ff[i] <= d1_side_ff[i-1];
      end
      d2_side_ff[0] <= m_side;
      for (int i = 1; i < D2; i++) begin
         d2_side_ff[i] <= d2_side_ff[i-1];
      end
   end

   sftc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .valid_i (d1_valid_ff[D1-1]),
      .side_i  (d1_side_ff[D1-1]),
      .rem_i   (d1_rem[D1]),
      .quo_i   (d1_quo[D1]),
      .rate_i  (rate_eff),
      .valid_o (m_valid),
      .side_o  (m_side),
      .rem_o   (d2_rem[0]),
      .quo_o   (d2_quo[0]),
      .dvs_o   (d2_dvs[0])
   );

   for (genvar g = 0; g < D2; g++) begin : g_div2
      sftc_div_stage u_stage (
         .clock (clock),
         .rem_i (d2_rem[g]),
         .quo_i (d2_quo[g]),
         .dvs_i (d2_dvs[g]),
         .rem_o (d2_rem[g+1]),
         .quo_o (d2_quo[g+1]),
         .dvs_o (d2_dvs[g+1])
      );
   end

   sftc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .valid_i       (d2_valid_ff[D2-1]),
      .side_i        (d2_side_ff[D2-1]),
      .quo_i         (d2_quo[D2]),
      .strobe_o      (rsp_strobe),
      .seconds_o     (rsp_seconds_out),
      .nanoseconds_o (rsp_nanoseconds_out),
      .frame_o       (rsp_frame_out),
      .overflow_o    (rsp_overflow)
   );

endmodule

### tb/tb_sample_frame_time_converter.sv
`timescale 1ns / 100ps

module tb_sample_frame_time_converter;

   localparam int LATENCY     = sftc_pkg::DIV1_STAGES + sftc_pkg::DIV2_STAGES + 3;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint NS_ONE  = 64'd1000000000;
   localparam int FW          = sftc_pkg::FRAME_WIDTH;
   localparam int NW          = sftc_pkg::NSEC_WIDTH;

   typedef struct {
      logic signed [31:0]    seconds;
      logic signed [NW-1:0]  nanoseconds;
      logic signed [FW-1:0]  frame;
      logic                  overflow;
   } conversion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = 2'd0;
   logic signed [FW-1:0] req_frame_in = '0;
   logic signed [31:0] req_seconds_in = '0;
   logic signed [31:0] req_nanoseconds_in = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_seconds_out;
   logic signed [NW-1:0] rsp_nanoseconds_out;
   logic signed [FW-1:0] rsp_frame_out;
   logic rsp_overflow;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [sftc_pkg::ADDR_WIDTH-1:0] paddr = '0;
   logic [sftc_pkg::DATA_WIDTH-1:0] pwdata = '0;
   logic [sftc_pkg::DATA_WIDTH-1:0] prdata;
   logic pready;

   logic [sftc_pkg::RATE_WIDTH-1:0] rate_model;
   conversion_type pending_conversions[$];
   int mismatch_count = 0;
   int cycle_count = 0;

   sample_frame_time_converter i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_frame_in(req_frame_in),
      .req_seconds_in(req_seconds_in), .req_nanoseconds_in(req_nanoseconds_in),
      .rsp_strobe(rsp_strobe), .rsp_seconds_out(rsp_seconds_out),
      .rsp_nanoseconds_out(rsp_nanoseconds_out), .rsp_frame_out(rsp_frame_out),
      .rsp_overflow(rsp_overflow), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_sample_frame_time_converter: errors");
         $finish;
      end
   end

   // saturate a seconds/nanoseconds pair and apply its sign
   function automatic void pack_time(input bit neg, input logic [63:0] smag,
                                     input logic [63:0] nmag, ref conversion_type c);
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (smag > lim) begin
         smag = lim;
         nmag = NS_ONE - 1;
         c.overflow = 1'b1;
      end
      if (neg) begin
         smag = -smag;
         nmag = -nmag;
      end
      c.seconds = smag[31:0];
      c.nanoseconds = nmag[NW-1:0];
   endfunction

   function automatic conversion_type convert(input logic [1:0] action,
                                              input logic signed [FW-1:0] frame,
                                              input logic signed [31:0] sec,
                                              input logic signed [31:0] nsec);
      conversion_type c;
      logic [63:0] rate, mag, total, fm, lim;
      longint signed t;
      bit neg;
      c = '{default: '0};
      rate = (rate_model == 0) ? 64'd1 : 64'(rate_model);
      t = longint'(sec) * NS_ONE + longint'(nsec);
      neg = t < 0;
      total = neg ? -t : t;
      unique case (action)
         sftc_pkg::ACT_TO_TIME: begin
            neg = frame[FW-1];
            mag = neg ? 64'(-longint'(frame)) : 64'(frame);
            pack_time(neg, mag / rate, ((mag % rate) * NS_ONE) / rate, c);
         end
         sftc_pkg::ACT_TO_FRAME: begin
            fm = (total / NS_ONE) * rate + (((total % NS_ONE) + 1) * rate) / NS_ONE;
            lim = (64'd1 << (FW - 1)) - (neg ? 0 : 1);
            if (fm > lim) begin
               fm = lim;
               c.overflow = 1'b1;
            end
            c.frame = neg ? -fm : fm;
         end
         sftc_pkg::ACT_NORMALIZE: pack_time(neg, total / NS_ONE, total % NS_ONE, c);
         default: ;
      endcase
      return c;
   endfunction

   always @(posedge clock) begin
      conversion_type e;
      if (!reset && rsp_strobe) begin
         if (pending_conversions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response");
         end else begin
            e = pending_conversions.pop_front();
            if (e.seconds !== rsp_seconds_out || e.nanoseconds !== rsp_nanoseconds_out ||
                e.frame !== rsp_frame_out || e.overflow !== rsp_overflow) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                           e.seconds, e.nanoseconds, e.frame, e.overflow, rsp_seconds_out,
                           rsp_nanoseconds_out, rsp_frame_out, rsp_overflow);
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] action,
                               input logic signed [FW-1:0] frame,
                               input logic signed [31:0] sec,
                               input logic signed [31:0] nsec,
                               input bit keep_start);
      req_action <= action;
      req_frame_in <= frame;
      req_seconds_in <= sec;
      req_nanoseconds_in <= nsec;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_conversions.push_back(convert(action, frame, sec, nsec));
      @(negedge clock);
      if (!keep_start) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drain;
      while (pending_conversions.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_rate(input logic [31:0] value);
      logic [31:0] readback;
      drain();
      psel <= 1'b1; pwrite <= 1'b1; paddr <= sftc_pkg::REG_RATE_ADDR; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rate_model = value[sftc_pkg::RATE_WIDTH-1:0];
      @(negedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      if (readback[sftc_pkg::RATE_WIDTH-1:0] !== rate_model) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("rate readback exp %0d got %0d", rate_model, readback);
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   task automatic test_directed;
      logic signed [FW-1:0] fmax, fmin;
      fmax = {1'b0, {(FW-1){1'b1}}};
      fmin = {1'b1, {(FW-1){1'b0}}};
      send_request(sftc_pkg::ACT_TO_TIME, 0, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, fmax, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, fmin, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, -1, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, 47999, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 32'h8000_0000, 32'h8000_0000, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 0, -1, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 1, -999999999, 0);
      send_request(sftc_pkg::ACT_NORMALIZE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_request(sftc_pkg::ACT_NORMALIZE, 0, 32'h8000_0000, 32'h8000_0000, 0);
      send_request(sftc_pkg::ACT_NORMALIZE, 0, 1, -1, 0);
      send_request(sftc_pkg::ACT_NORMALIZE, 0, -1, 1999999999, 0);
      send_request(sftc_pkg::ACT_NONE, fmax, -1, -1, 0);
      write_rate(0);
      send_request(sftc_pkg::ACT_TO_TIME, fmax, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, fmin, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 32'h7FFF_FFFF, 0, 0);
      write_rate(32'hFFFF_FFFF);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_request(sftc_pkg::ACT_TO_FRAME, 0, 32'h8000_0000, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, fmin, 0, 0, 0);
      send_request(sftc_pkg::ACT_TO_TIME, -12345, 0, 0, 0);
   endtask

   task automatic test_random(input int count);
      int burst;
      logic [1:0] action;
      logic [63:0] bits;
      logic signed [31:0] sec, nsec;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            action = ($urandom_range(0, 19) == 0) ? sftc_pkg::ACT_NONE :
                     2'($urandom_range(0, 2));
            bits = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) bits = bits >> $urandom_range(0, 63);
            if ($urandom_range(0, 1)) bits = -bits;
            sec = $urandom;
            nsec = $urandom;
            case ($urandom_range(0, 3))
               0: sec = $signed($urandom_range(0, 4000)) - 2000;
               1: nsec = $signed($urandom_range(0, 1999999999)) - 999999999;
               default: ;
            endcase
            send_request(action, bits[FW-1:0], sec, nsec, burst > 1 && count > 1);
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   initial begin
      rate_model = sftc_pkg::RATE_RESET;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      write_rate(48000);
      test_random(500);
      write_rate(1);
      test_random(350);
      write_rate(1048575);
      test_random(350);
      write_rate(44100);
      test_random(400);
      write_rate($urandom_range(2, 1048574));
      test_random(350);
      drain();
      if (mismatch_count == 0 && pending_conversions.size() == 0)
         $display("tb_sample_frame_time_converter: clean");
      else
         $display("tb_sample_frame_time_converter: errors");
      $finish;
   end

endmodule
